>>> src/atc_pkg.sv
// shared types and constants for the affine transform composer
`default_nettype none
package atc_pkg;

  typedef enum logic [2:0] {
    MODE_IDENT  = 3'd0,
    MODE_ROTVEC = 3'd1,
    MODE_ROTANG = 3'd2,
    MODE_TRANS  = 3'd3,
    MODE_POINT  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [15:0]        angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic               is_ident;
    logic               is_point;
    logic               use_cordic;
    logic               flip;
    logic signed [31:0] z0;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] t31;
    logic signed [31:0] t32;
  } cmd_t;

  localparam int AtanCount = 31;
  localparam logic signed [31:0] CordicGain = 32'sd652032875;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd536870912;   5'd1: r = 32'sd316933406;
        5'd2: r = 32'sd167458907;   5'd3: r = 32'sd85004756;
        5'd4: r = 32'sd42667331;    5'd5: r = 32'sd21354465;
        5'd6: r = 32'sd10679838;    5'd7: r = 32'sd5340245;
        5'd8: r = 32'sd2670163;     5'd9: r = 32'sd1335087;
        5'd10: r = 32'sd667544;     5'd11: r = 32'sd333772;
        5'd12: r = 32'sd166886;     5'd13: r = 32'sd83443;
        5'd14: r = 32'sd41722;      5'd15: r = 32'sd20861;
        5'd16: r = 32'sd10430;      5'd17: r = 32'sd5215;
        5'd18: r = 32'sd2608;       5'd19: r = 32'sd1304;
        5'd20: r = 32'sd652;        5'd21: r = 32'sd326;
        5'd22: r = 32'sd163;        5'd23: r = 32'sd81;
        5'd24: r = 32'sd41;         5'd25: r = 32'sd20;
        5'd26: r = 32'sd10;         5'd27: r = 32'sd5;
        5'd28: r = 32'sd3;          5'd29: r = 32'sd1;
        5'd30: r = 32'sd1;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    begin
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CORDIC = 3'd1,
    ST_MAC    = 3'd2,
    ST_OUT    = 3'd3
  } state_e;

endpackage
`default_nettype wire

>>> src/atc_front.sv
// front part: accepts commands, classifies them and queues them for the back part
`default_nettype none
module atc_front #(
  parameter int FracBits = 16,
  parameter int Depth    = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire atc_pkg::in_item_t in_data_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_take_i,
  output atc_pkg::cmd_t         cmd_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  atc_pkg::cmd_t    fifo_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  atc_pkg::cmd_t    cls;
  logic             push, pop, keep;
  logic [31:0]      w;
  logic [1:0]       quad;
  logic signed [31:0] one;

  assign one  = 32'sd1 <<< FracBits;
  assign quad = in_data_i.angle[15:14];
  assign w    = {in_data_i.angle, 16'd0};

  always_comb begin
    cls = '0;
    cls.is_ident   = (in_data_i.mode == atc_pkg::MODE_IDENT);
    cls.is_point   = (in_data_i.mode == atc_pkg::MODE_POINT);
    cls.use_cordic = (in_data_i.mode == atc_pkg::MODE_ROTANG);
    cls.flip       = (quad == 2'd1) || (quad == 2'd2);
    cls.z0         = cls.flip ? $signed(w - 32'h80000000) : $signed(w);
    cls.m11 = in_data_i.first_x;
    cls.m12 = in_data_i.first_y;
    cls.m21 = in_data_i.second_x;
    cls.m22 = in_data_i.second_y;
    if (in_data_i.mode == atc_pkg::MODE_TRANS) begin
      cls.m11 = one; cls.m12 = '0; cls.m21 = '0; cls.m22 = one;
      cls.t31 = in_data_i.first_x;
      cls.t32 = in_data_i.first_y;
    end else if (in_data_i.mode == atc_pkg::MODE_POINT) begin
      cls.t31 = in_data_i.first_x;
      cls.t32 = in_data_i.first_y;
    end
  end

  // modes five to seven are dropped here
  assign keep     = (in_data_i.mode <= atc_pkg::MODE_POINT);
  assign in_stall = (cnt_q == (PtrW+1)'(Depth));
  assign push     = in_valid && !in_stall && keep;
  assign pop      = cmd_take_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o    = fifo_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cls;
  end
endmodule
`default_nettype wire

>>> src/atc_back.sv
// back part: cordic, shared multiply-accumulate and transform state
`default_nettype none
module atc_back #(
  parameter int FracBits    = 16,
  parameter int CordicSteps = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_take_o,
  input  wire atc_pkg::cmd_t     cmd_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output atc_pkg::out_item_t     out_data_o
);
  localparam int StepW  = 5;
  localparam int Steps  = (CordicSteps < atc_pkg::AtanCount) ? CordicSteps
                                                            : atc_pkg::AtanCount;
  localparam int OutSh  = 30 - FracBits;

  atc_pkg::state_e state_q, state_d;
  atc_pkg::cmd_t   cmd_q;
  logic signed [31:0] lin_q [4];
  logic signed [31:0] off_q [2];
  logic signed [31:0] new_q [6];
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [StepW-1:0]   step_q;
  logic [2:0]         idx_q;
  logic               ph_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;
  atc_pkg::out_item_t out_q;
  logic               ov_q;
  logic signed [31:0] m11, m12, m21, m22;
  logic signed [31:0] sin_v, cos_v;
  logic signed [33:0] sx, sy;
  logic signed [31:0] ma, mb;
  logic signed [65:0] fin;
  logic               last_idx, take, accept;

  assign take       = (state_q == atc_pkg::ST_IDLE) && cmd_valid_i;
  assign cmd_take_o = take;
  assign out_valid  = ov_q;
  assign out_data_o = out_q;
  assign accept     = ov_q && !out_stall;

  assign sx = cx_q >>> OutSh;
  assign sy = cy_q >>> OutSh;
  assign cos_v = cmd_q.flip ? -sx[31:0] : sx[31:0];
  assign sin_v = cmd_q.flip ? -sy[31:0] : sy[31:0];
  assign m11 = cmd_q.use_cordic ? cos_v : cmd_q.m11;
  assign m12 = cmd_q.use_cordic ? sin_v : cmd_q.m12;
  assign m21 = cmd_q.use_cordic ? -sin_v : cmd_q.m21;
  assign m22 = cmd_q.use_cordic ? cos_v : cmd_q.m22;

  // element idx: 0..3 linear, 4..5 offset; point uses 0..1
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_q.is_point) begin
      unique case ({idx_q[0], ph_q})
        2'b00: begin ma = lin_q[0]; mb = cmd_q.t31; end
        2'b01: begin ma = lin_q[2]; mb = cmd_q.t32; end
        2'b10: begin ma = lin_q[1]; mb = cmd_q.t31; end
        default: begin ma = lin_q[3]; mb = cmd_q.t32; end
      endcase
    end else begin
      unique case (idx_q)
        3'd0: begin ma = ph_q ? lin_q[1] : lin_q[0]; end
        3'd1: begin ma = ph_q ? lin_q[1] : lin_q[0]; end
        3'd2: begin ma = ph_q ? lin_q[3] : lin_q[2]; end
        3'd3: begin ma = ph_q ? lin_q[3] : lin_q[2]; end
        3'd4: begin ma = ph_q ? off_q[1] : off_q[0]; end
        default: begin ma = ph_q ? off_q[1] : off_q[0]; end
      endcase
      if (idx_q[0]) mb = ph_q ? m22 : m12;
      else          mb = ph_q ? m21 : m11;
    end
  end

  // exact sum of two products floored equals floor of the sum
  always_comb begin
    fin = (acc_q + 66'(prod_q)) >>> FracBits;
    if (cmd_q.is_point)
      fin = fin + (idx_q[0] ? 66'(off_q[1]) : 66'(off_q[0]));
    else if (idx_q == 3'd4) fin = fin + 66'(cmd_q.t31);
    else if (idx_q == 3'd5) fin = fin + 66'(cmd_q.t32);
  end

  assign last_idx = cmd_q.is_point ? (idx_q == 3'd1) : (idx_q == 3'd5);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atc_pkg::ST_IDLE: begin
        if (take && !cmd_i.is_ident)
          state_d = cmd_i.use_cordic ? atc_pkg::ST_CORDIC : atc_pkg::ST_MAC;
      end
      atc_pkg::ST_CORDIC: begin
        if (step_q == StepW'(Steps)) state_d = atc_pkg::ST_MAC;
      end
      atc_pkg::ST_MAC: begin
        if (step_q == StepW'(3) && last_idx)
          state_d = cmd_q.is_point ? atc_pkg::ST_OUT : atc_pkg::ST_IDLE;
      end
      atc_pkg::ST_OUT: begin
        if (!ov_q || accept) state_d = atc_pkg::ST_IDLE;
      end
      default: state_d = atc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atc_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      lin_q[0] <= 32'sd1 <<< FracBits;
      lin_q[1] <= '0;
      lin_q[2] <= '0;
      lin_q[3] <= 32'sd1 <<< FracBits;
      off_q[0] <= '0;
      off_q[1] <= '0;
      step_q  <= '0;
      idx_q   <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == atc_pkg::ST_OUT && (!ov_q || accept)) ov_q <= 1'b1;
      else if (accept) ov_q <= 1'b0;
      unique case (state_q)
        atc_pkg::ST_IDLE: begin
          step_q <= '0;
          idx_q  <= '0;
          ph_q   <= 1'b0;
          if (take && cmd_i.is_ident) begin
            lin_q[0] <= 32'sd1 <<< FracBits;
            lin_q[1] <= '0;
            lin_q[2] <= '0;
            lin_q[3] <= 32'sd1 <<< FracBits;
            off_q[0] <= '0;
            off_q[1] <= '0;
          end
        end
        atc_pkg::ST_CORDIC: begin
          step_q <= (step_q == StepW'(Steps)) ? '0 : step_q + 1'b1;
        end
        atc_pkg::ST_MAC: begin
          // step 0 mult a, 1 add, 2 mult b, 3 add and finish
          step_q <= (step_q == StepW'(3)) ? '0 : step_q + 1'b1;
          if (step_q == StepW'(0)) ph_q <= 1'b1;
          if (step_q == StepW'(3)) begin
            ph_q   <= 1'b0;
            new_q[idx_q] <= atc_pkg::sat32(fin);
            if (last_idx) begin
              if (!cmd_q.is_point) begin
                lin_q[0] <= new_q[0];
                lin_q[1] <= new_q[1];
                lin_q[2] <= new_q[2];
                lin_q[3] <= new_q[3];
                off_q[0] <= new_q[4];
                off_q[1] <= atc_pkg::sat32(fin);
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        atc_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      cx_q  <= 34'(atc_pkg::CordicGain);
      cy_q  <= '0;
      cz_q  <= cmd_i.z0;
    end
    if (state_q == atc_pkg::ST_CORDIC && step_q != StepW'(Steps)) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - (cy_q >>> step_q);
        cy_q <= cy_q + (cx_q >>> step_q);
        cz_q <= cz_q - atc_pkg::atan_lut(step_q);
      end else begin
        cx_q <= cx_q + (cy_q >>> step_q);
        cy_q <= cy_q - (cx_q >>> step_q);
        cz_q <= cz_q + atc_pkg::atan_lut(step_q);
      end
    end
    if (state_q == atc_pkg::ST_MAC) begin
      if (step_q == StepW'(0) || step_q == StepW'(2)) prod_q <= ma * mb;
      if (step_q == StepW'(1)) acc_q <= 66'(prod_q);
    end
    if (state_q == atc_pkg::ST_OUT && (!ov_q || accept)) begin
      out_q.out_x <= new_q[0];
      out_q.out_y <= new_q[1];
    end
  end
endmodule
`default_nettype wire

>>> src/affine_2d_transform_composer_unit.sv
// top level of the 2d affine transform composer
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall   | in_data_i  (atc_pkg::in_item_t)
//  out     | out | out_valid/out_stall | out_data_o (atc_pkg::out_item_t)
//
// the back part takes a command from the queue when it is idle.
// identity is done in the take itself; translate and vector rotate then compute
// six elements, each by a multiply, an add, a second multiply and a final add;
// angle rotate runs the cordic before that; a point computes two elements and
// then registers its result for the output channel.
// a two-entry command queue lets input be taken while the back part works.
// reset loads the identity transform; a stalled result holds the back part.
`default_nettype none
module affine_2d_transform_composer_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire atc_pkg::in_item_t  in_data_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output atc_pkg::out_item_t      out_data_o
);
  logic          cmd_valid, cmd_take;
  atc_pkg::cmd_t cmd;

  atc_front #(.FracBits(FRAC_BITS), .Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  atc_back #(.FracBits(FRAC_BITS), .CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid, .out_stall, .out_data_o
  );
endmodule
`default_nettype wire

>>> verif/tb_affine_2d_transform_composer_unit.sv
// testbench for the affine transform composer: directed and random command streams checked against a predictor
`default_nettype none
module tb_affine_2d_transform_composer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam int Steps = 16;
  localparam int NumRandom = 550;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 100;
  localparam logic [2:0] ModeNopLo = 3'd5;
  localparam logic [2:0] ModeNopHi = 3'd7;

  class transform_scoreboard;
    logic signed [31:0] lin[4];
    logic signed [31:0] ofs[2];
    atc_pkg::out_item_t points_q[$];
    int errors;
    longint turn_atan[31];

    function new();
      turn_atan = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                    81, 41, 20, 10, 5, 3, 1, 1};
      errors = 0;
      load_identity();
    endfunction

    function void load_identity();
      lin[0] = 32'sd1 <<< FracBits;
      lin[1] = '0;
      lin[2] = '0;
      lin[3] = 32'sd1 <<< FracBits;
      ofs[0] = '0;
      ofs[1] = '0;
    endfunction

    function logic signed [31:0] clamp(logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fffffff;
      if (v < -96'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // floor((a*b + c*d) / 2^frac) plus offset, saturated
    function logic signed [31:0] mac(longint a, longint b, longint c, longint d, longint t);
      logic signed [95:0] pa, pc, s;
      pa = a;
      pc = c;
      s = pa * b + pc * d;
      s = s >>> FracBits;
      s = s + t;
      return clamp(s);
    endfunction

    function void sin_cos(logic [15:0] ang, output longint s, output longint c);
      logic [31:0] w;
      logic flip;
      longint x, y, z, dx, dy;
      flip = (ang[15:14] == 2'd1) || (ang[15:14] == 2'd2);
      w = {ang, 16'h0};
      if (flip) w = w - 32'h80000000;
      z = longint'($signed(w));
      x = 652032875;
      y = 0;
      for (int i = 0; i < Steps && i < 31; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= turn_atan[i];
        end else begin
          x += dx; y -= dy; z += turn_atan[i];
        end
      end
      x = x >>> (30 - FracBits);
      y = y >>> (30 - FracBits);
      if (flip) begin
        x = -x; y = -y;
      end
      c = x;
      s = y;
    endfunction

    function void compose(longint m11, longint m12, longint m21, longint m22,
                          longint t31, longint t32);
      longint a, b, c, d, e, f;
      a = lin[0]; b = lin[1]; c = lin[2]; d = lin[3]; e = ofs[0]; f = ofs[1];
      lin[0] = mac(a, m11, b, m21, 0);
      lin[1] = mac(a, m12, b, m22, 0);
      lin[2] = mac(c, m11, d, m21, 0);
      lin[3] = mac(c, m12, d, m22, 0);
      ofs[0] = mac(e, m11, f, m21, t31);
      ofs[1] = mac(e, m12, f, m22, t32);
    endfunction

    function void note_command(atc_pkg::in_item_t it);
      longint s, c, one;
      atc_pkg::out_item_t p;
      one = longint'(1) << FracBits;
      case (it.mode)
        atc_pkg::MODE_IDENT: load_identity();
        atc_pkg::MODE_ROTVEC:
          compose(it.first_x, it.first_y, it.second_x, it.second_y, 0, 0);
        atc_pkg::MODE_ROTANG: begin
          sin_cos(it.angle, s, c);
          compose(c, s, -s, c, 0, 0);
        end
        atc_pkg::MODE_TRANS: compose(one, 0, 0, one, it.first_x, it.first_y);
        atc_pkg::MODE_POINT: begin
          p.out_x = mac(lin[0], it.first_x, lin[2], it.first_y, ofs[0]);
          p.out_y = mac(lin[1], it.first_x, lin[3], it.first_y, ofs[1]);
          points_q.push_back(p);
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic signed [31:0] got, logic signed [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_point(atc_pkg::out_item_t got);
      atc_pkg::out_item_t want;
      if (points_q.size() == 0) begin
        report("unexpected item", got.out_x, 0);
        return;
      end
      want = points_q.pop_front();
      if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  atc_pkg::in_item_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  atc_pkg::out_item_t out_data_o;

  transform_scoreboard sb = new();
  int idle_cycles = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit out_took = 1'b0;
  int stall_left = 0;

  affine_2d_transform_composer_unit u_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .out_valid, .out_stall, .out_data_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_command(in_data_i);
      if (out_valid && !out_stall) begin
        sb.check_point(out_data_o);
        out_took = 1'b1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("affine_2d_transform_composer_unit test failed");
        $finish;
      end
    end
  end

  // one wait drawn for each item after the previous one is taken
  always @(negedge clk_i) begin
    if (out_took) begin
      out_took = 1'b0;
      stall_left = receiver_idles ? $urandom_range(0, 12) : 0;
      if ($urandom_range(0, 40) == 0) receiver_idles = !receiver_idles;
    end
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  task automatic send(atc_pkg::in_item_t it);
    int gap;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 40) == 0) sender_idles = !sender_idles;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data_i = it;
    while (in_stall) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(atc_pkg::mode_e m, logic signed [31:0] fx,
                          logic signed [31:0] fy, logic signed [31:0] sx,
                          logic signed [31:0] sy, logic [15:0] ang);
    atc_pkg::in_item_t it;
    it.mode = m;
    it.first_x = fx;
    it.first_y = fy;
    it.second_x = sx;
    it.second_y = sy;
    it.angle = ang;
    send(it);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.points_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    atc_pkg::in_item_t it;
    logic [15:0] angles[6];
    angles = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed
    send_cmd(atc_pkg::MODE_POINT, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
    send_cmd(atc_pkg::MODE_POINT, 32'sh00018000, -32'sh00020000, 0, 0, 0);
    foreach (angles[i]) begin
      send_cmd(atc_pkg::MODE_ROTANG, 0, 0, $urandom, $urandom, angles[i]);
      send_cmd(atc_pkg::MODE_POINT, 32'sh00010000, 32'sh00020000, 0, 0, 0);
    end
    send_cmd(atc_pkg::MODE_TRANS, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    send_cmd(atc_pkg::MODE_POINT, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
    send_cmd(atc_pkg::MODE_IDENT, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
    send_cmd(atc_pkg::MODE_ROTVEC, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
             32'sh80000000, 0);
    send_cmd(atc_pkg::MODE_POINT, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    it = '0;
    it.mode = ModeNopLo;
    send(it);
    it.mode = ModeNopHi;
    send(it);
    send_cmd(atc_pkg::MODE_IDENT, 0, 0, 0, 0, 0);
    send_cmd(atc_pkg::MODE_POINT, -32'sh00010000, 32'sh00008000, 0, 0, 0);
    drain();

    // random
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain();
      it.first_x = pick_value();
      it.first_y = pick_value();
      it.second_x = pick_value();
      it.second_y = pick_value();
      it.angle = 16'($urandom);
      case ($urandom_range(0, 19))
        0, 1, 2: it.mode = atc_pkg::MODE_IDENT;
        3, 4, 5: it.mode = atc_pkg::MODE_ROTVEC;
        6, 7, 8: it.mode = atc_pkg::MODE_ROTANG;
        9, 10, 11: it.mode = atc_pkg::MODE_TRANS;
        12: it.mode = 3'($urandom_range(ModeNopLo, ModeNopHi));
        default: it.mode = atc_pkg::MODE_POINT;
      endcase
      send(it);
    end
    in_valid = 1'b0;
    while (sb.points_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("affine_2d_transform_composer_unit test passed");
    end else begin
      $display("affine_2d_transform_composer_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
